// ----- rtl/fslm_pkg.sv -----
// Shared types, constants and register codes of the film-strip layout mapper.
`default_nettype none

package fslm_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int GEO_W       = 16;
    localparam int PIX_W       = 12;
    localparam int SRC_W       = 20;
    localparam int FRAC_W      = 8;
    localparam int MARGIN_DIV  = 6;
    localparam int GUTTER_DIV  = 24;
    localparam int CFG_DIM_W   = 13;
    localparam int CFG_FRM_W   = 5;
    localparam int CFG_HOLE_W  = 7;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 4;

    // (2^17 + 1) / 3: n * DIV3_RECIP >> 18 is n / 6 and >> 20 is n / 24, exact below 2^17
    localparam logic [31:0] DIV3_RECIP   = 32'd43691;
    localparam int          MARGIN_SHIFT = 18;
    localparam int          GUTTER_SHIFT = 20;

    localparam logic [CFG_DIM_W-1:0]  RST_WIDTH  = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0]  RST_HEIGHT = CFG_DIM_W'(480);
    localparam logic [CFG_FRM_W-1:0]  RST_FRAMES = CFG_FRM_W'(3);
    localparam logic [CFG_HOLE_W-1:0] RST_HOLE   = CFG_HOLE_W'(8);

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_FRAME_COUNT,
        REG_HOLE_SIZE
    } t_reg_idx;

    typedef enum logic [1:0] {
        CLASS_BLACK,
        CLASS_HOLE,
        CLASS_CONTENT
    } t_pix_class;

    typedef enum logic [1:0] {
        DRV_LOAD,
        DRV_CELL,
        DRV_GUTTER,
        DRV_DONE
    } t_drv_state;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [1:0]       pixel_class;
        logic [SRC_W-1:0] source_x;
        logic [SRC_W-1:0] source_y;
    } t_pix_out;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]  image_width;
        logic [CFG_DIM_W-1:0]  image_height;
        logic [CFG_FRM_W-1:0]  frame_count;
        logic [CFG_HOLE_W-1:0] hole_size;
    } t_cfg;

    typedef struct packed {
        logic [GEO_W-1:0]        w;
        logic [GEO_W-1:0]        h;
        logic [GEO_W-1:0]        frames;
        logic [GEO_W-1:0]        margin;
        logic [GEO_W-1:0]        h_less_m;
        logic [GEO_W-1:0]        ch;
        logic [GEO_W-1:0]        cell_w;
        logic [GEO_W-1:0]        gutter;
        logic [GEO_W-1:0]        cell_less_g;
        logic [GEO_W-1:0]        cw;
        logic [7:0]              pitch;
        logic [7:0]              off;
        logic [7:0]              off_end;
        logic signed [GEO_W-1:0] tlo;
        logic signed [GEO_W-1:0] thi;
        logic signed [GEO_W-1:0] blo;
        logic signed [GEO_W-1:0] bhi;
    } t_geom;

endpackage

`default_nettype wire

// ----- rtl/film_strip_layout_mapper.sv -----
// Top level of the film-strip layout mapper: registers, pixel pipeline and result stage.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------
//  pixel in  | start high, busy low    | i_item  (pixel_x, pixel_y)
//  result    | o_strobe, one cycle     | o_result (class, source_x/y)
//  config    | APB write, pready tied  | pwdata at paddr 4*index
//
// One item per clock while busy is low. A 12-cell chain takes x apart by the
// frame cell and the hole pitch, a product stage follows, then a chain of one
// cell per quotient bit forms both source coordinates ahead of the result stage.
// After reset and after every register write, busy stays high while a serial
// divider forms the cell width and reciprocal products form the margin and gutter.
// The receiver cannot stall; results are never held.
`default_nettype none

module film_strip_layout_mapper #(
    parameter int MAX_DIM = fslm_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  fslm_pkg::t_pix_in             i_item,
    output logic                          o_strobe,
    output fslm_pkg::t_pix_out            o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fslm_pkg::APB_AW-1:0]   paddr,
    input  logic [fslm_pkg::APB_DW-1:0]   pwdata,
    output logic [fslm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int DW   = $clog2(MAX_DIM) + 1;
    localparam int LW   = $clog2(MAX_DIM);
    localparam int GW   = fslm_pkg::GEO_W;
    localparam int PW   = fslm_pkg::PIX_W;
    localparam int RW_A = (DW > 8) ? DW : 8;
    localparam int QB_B = LW + fslm_pkg::FRAC_W;
    localparam int SW_A = PW + 3;

    // ---------------- configuration registers ----------------
    fslm_pkg::t_cfg  r_cfg, n_cfg;
    fslm_pkg::t_geom w_geo;
    logic            w_wr, w_busy;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // write the addressed register, hold the rest
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (fslm_pkg::t_reg_idx'(paddr[3:2]))
                fslm_pkg::REG_IMAGE_WIDTH:  n_cfg.image_width  = pwdata[12:0];
                fslm_pkg::REG_IMAGE_HEIGHT: n_cfg.image_height = pwdata[12:0];
                fslm_pkg::REG_FRAME_COUNT:  n_cfg.frame_count  = pwdata[4:0];
                fslm_pkg::REG_HOLE_SIZE:    n_cfg.hole_size    = pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (fslm_pkg::t_reg_idx'(paddr[3:2]))
            fslm_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_cfg.image_width);
            fslm_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_cfg.image_height);
            fslm_pkg::REG_FRAME_COUNT:  prdata = 32'(r_cfg.frame_count);
            fslm_pkg::REG_HOLE_SIZE:    prdata = 32'(r_cfg.hole_size);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= fslm_pkg::RST_WIDTH;
            r_cfg.image_height <= fslm_pkg::RST_HEIGHT;
            r_cfg.frame_count  <= fslm_pkg::RST_FRAMES;
            r_cfg.hole_size    <= fslm_pkg::RST_HOLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // refresh the geometry after reset and after every write
    fslm_derive #(
        .MAX_DIM (MAX_DIM)
    ) u_derive (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_wr),
        .i_cfg     (r_cfg),
        .o_busy    (w_busy),
        .o_geo     (w_geo)
    );

    assign busy = w_busy;

    // ---------------- entry: vertical tests ----------------
    logic                  w_acc, w_inside, w_band, w_top, w_yok;
    logic [GW-1:0]         w_x, w_y;
    logic signed [GW-1:0]  s_y, s_lo, s_hi;

    always_comb begin
        w_acc    = start && !w_busy;
        w_x      = GW'(i_item.pixel_x);
        w_y      = GW'(i_item.pixel_y);
        s_y      = $signed(w_y);
        w_inside = (w_x < w_geo.w) && (w_y < w_geo.h);
        w_band   = (w_y >= w_geo.margin) && (w_y < w_geo.h_less_m);
        // the top band wins where the two bands overlap
        w_top    = (w_y < w_geo.margin);
        s_lo     = w_top ? w_geo.tlo : w_geo.blo;
        s_hi     = w_top ? w_geo.thi : w_geo.bhi;
        w_yok    = (s_y >= s_lo) && (s_y < s_hi);
    end

    // ---------------- chain A: x by cell width and by hole pitch ----------------
    logic                 a_valid;
    logic [1:0][RW_A-1:0] a_rem;
    logic [1:0][PW-1:0]   a_lo;
    logic [SW_A-1:0]      a_side;

    fslm_div_chain #(
        .RW (RW_A),
        .QB (PW),
        .SW (SW_A)
    ) u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_rem   ('0),
        .i_lo    ({i_item.pixel_x, i_item.pixel_x}),
        .i_div   ({RW_A'(w_geo.pitch), RW_A'(w_geo.cell_w)}),
        .i_side  ({i_item.pixel_y, w_inside, w_band, w_yok}),
        .o_valid (a_valid),
        .o_rem   (a_rem),
        .o_lo    (a_lo),
        .o_side  (a_side)
    );

    // ---------------- classify and form the numerators ----------------
    logic [PW-1:0]   w_ay;
    logic            w_ain, w_aband, w_ayok, w_content, w_hole;
    logic [GW-1:0]   w_lx, w_phase;
    logic [DW-1:0]   w_dx, w_dy;
    logic [2*DW-1:0] w_px, w_py;
    logic [1:0]      w_cls;

    logic            r_m_valid;
    logic [1:0]      r_m_cls;
    logic [2*DW-1:0] r_m_px, r_m_py;

    always_comb begin
        {w_ay, w_ain, w_aband, w_ayok} = a_side;
        w_lx      = GW'(a_rem[0]);
        w_phase   = GW'(a_rem[1]);
        w_content = w_ain && w_aband && (GW'(a_lo[0]) < w_geo.frames)
                    && (w_lx >= w_geo.gutter) && (w_lx < w_geo.cell_less_g);
        w_hole    = w_ain && !w_aband && w_ayok
                    && (w_phase >= GW'(w_geo.off)) && (w_phase < GW'(w_geo.off_end));
        if (w_content) begin
            w_cls = fslm_pkg::CLASS_CONTENT;
        end else if (w_hole) begin
            w_cls = fslm_pkg::CLASS_HOLE;
        end else begin
            w_cls = fslm_pkg::CLASS_BLACK;
        end
        // offsets wrap on non-content pixels; their results are dropped
        w_dx = DW'(w_lx - w_geo.gutter);
        w_dy = DW'(GW'(w_ay) - w_geo.margin);
        w_px = {{DW{1'b0}}, w_dx} * {{DW{1'b0}}, DW'(w_geo.w)};
        w_py = {{DW{1'b0}}, w_dy} * {{DW{1'b0}}, DW'(w_geo.h)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_cls <= w_cls;
        r_m_px  <= w_px;
        r_m_py  <= w_py;
    end

    // ---------------- chain B: scaled offsets by content width and height ----------------
    logic                 b_valid;
    logic [1:0][QB_B-1:0] b_lo;
    logic [1:0]           b_side;

    // the top part of the numerator is already below the divisor
    fslm_div_chain #(
        .RW (DW),
        .QB (QB_B),
        .SW (2)
    ) u_chain_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_valid),
        .i_rem   ({DW'(r_m_py >> LW), DW'(r_m_px >> LW)}),
        .i_lo    ({{r_m_py[LW-1:0], {fslm_pkg::FRAC_W{1'b0}}},
                   {r_m_px[LW-1:0], {fslm_pkg::FRAC_W{1'b0}}}}),
        .i_div   ({DW'(w_geo.ch), DW'(w_geo.cw)}),
        .i_side  (r_m_cls),
        .o_valid (b_valid),
        .o_rem   (),
        .o_lo    (b_lo),
        .o_side  (b_side)
    );

    // ---------------- result register ----------------
    logic               r_out_valid;
    fslm_pkg::t_pix_out r_out, n_out;

    always_comb begin
        n_out.pixel_class = b_side;
        if (b_side == fslm_pkg::CLASS_CONTENT) begin
            n_out.source_x = fslm_pkg::SRC_W'(b_lo[0]);
            n_out.source_y = fslm_pkg::SRC_W'(b_lo[1]);
        end else begin
            n_out.source_x = '0;
            n_out.source_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- rtl/fslm_div_cell.sv -----
// One restoring-division step for two lanes, with a registered sideband.
`default_nettype none

module fslm_div_cell #(
    parameter int RW = 13,
    parameter int QB = 12,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [1:0][RW-1:0]     i_rem,
    input  logic [1:0][QB-1:0]     i_lo,
    input  logic [1:0][RW-1:0]     i_div,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [1:0][RW-1:0]     o_rem,
    output logic [1:0][QB-1:0]     o_lo,
    output logic [SW-1:0]          o_side
);

    logic [1:0][RW:0]   w_cand;
    logic [1:0]         w_take;
    logic [1:0][RW-1:0] n_rem;
    logic [1:0][QB-1:0] n_lo;
    logic               r_valid;
    logic [1:0][RW-1:0] r_rem;
    logic [1:0][QB-1:0] r_lo;
    logic [SW-1:0]      r_side;

    // shift in the next dividend bit, subtract where it fits
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_cand[k] = {i_rem[k], i_lo[k][QB-1]};
            w_take[k] = (w_cand[k] >= {1'b0, i_div[k]});
            n_rem[k]  = w_take[k] ? RW'(w_cand[k] - {1'b0, i_div[k]}) : w_cand[k][RW-1:0];
            n_lo[k]   = {i_lo[k][QB-2:0], w_take[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_lo   <= n_lo;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_lo    = r_lo;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ----- rtl/fslm_div_chain.sv -----
// Row of division cells, one quotient bit per cell, one item per clock.
`default_nettype none

module fslm_div_chain #(
    parameter int RW = 13,
    parameter int QB = 12,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [1:0][RW-1:0]     i_rem,
    input  logic [1:0][QB-1:0]     i_lo,
    input  logic [1:0][RW-1:0]     i_div,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [1:0][RW-1:0]     o_rem,
    output logic [1:0][QB-1:0]     o_lo,
    output logic [SW-1:0]          o_side
);

    logic [QB:0]                w_valid;
    logic [QB:0][1:0][RW-1:0]   w_rem;
    logic [QB:0][1:0][QB-1:0]   w_lo;
    logic [QB:0][SW-1:0]        w_side;

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_rem;
    assign w_lo[0]    = i_lo;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < QB; g++) begin : g_cell
        fslm_div_cell #(
            .RW (RW),
            .QB (QB),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_lo    (w_lo[g]),
            .i_div   (i_div),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_lo    (w_lo[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[QB];
    assign o_rem   = w_rem[QB];
    assign o_lo    = w_lo[QB];
    assign o_side  = w_side[QB];

endmodule

`default_nettype wire

// ----- rtl/fslm_derive.sv -----
// Layout geometry from the registers: a serial divider for the cell width and a sequencer.
`default_nettype none

module fslm_derive #(
    parameter int MAX_DIM = fslm_pkg::MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_restart,
    input  fslm_pkg::t_cfg       i_cfg,
    output logic                 o_busy,
    output fslm_pkg::t_geom      o_geo
);

    localparam int DW    = $clog2(MAX_DIM) + 1;
    localparam int CNT_W = $clog2(DW);
    localparam int GW    = fslm_pkg::GEO_W;

    fslm_pkg::t_drv_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_lo, n_lo;
    logic [DW-1:0]    r_margin, r_cell, r_gutter;

    logic [DW-1:0]                      w_w, w_h, w_div, w_rem_nx, w_lo_nx, w_q1;
    logic [DW-1:0]                      w_mq, w_m1, w_gq, w_g1;
    logic [31:0]                        w_mprod, w_gprod;
    logic [fslm_pkg::CFG_FRM_W-1:0]     w_frames;
    logic [fslm_pkg::CFG_HOLE_W-1:0]    w_hs, w_half;
    logic [DW:0]                        w_cand;
    logic                               w_take, w_last;
    logic signed [GW-1:0]               s_h, s_m, s_cell, s_g, s_ch, s_cw, s_half;
    logic signed [GW-1:0]               s_tcy, s_bcy;

    // zero reads as one, oversize saturates
    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_w = DW'(1);
        end else if (32'(i_cfg.image_width) > MAX_DIM) begin
            w_w = DW'(MAX_DIM);
        end else begin
            w_w = DW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            w_h = DW'(1);
        end else if (32'(i_cfg.image_height) > MAX_DIM) begin
            w_h = DW'(MAX_DIM);
        end else begin
            w_h = DW'(i_cfg.image_height);
        end
        w_frames = (i_cfg.frame_count == '0) ? fslm_pkg::CFG_FRM_W'(1) : i_cfg.frame_count;
        w_hs     = (i_cfg.hole_size == '0) ? fslm_pkg::CFG_HOLE_W'(1) : i_cfg.hole_size;
    end

    // margin and gutter by reciprocal multiplication, at least one
    always_comb begin
        w_mprod = 32'(w_h) * fslm_pkg::DIV3_RECIP;
        w_mq    = DW'(w_mprod >> fslm_pkg::MARGIN_SHIFT);
        w_m1    = (w_mq == '0) ? DW'(1) : w_mq;
        w_gprod = 32'(r_cell) * fslm_pkg::DIV3_RECIP;
        w_gq    = DW'(w_gprod >> fslm_pkg::GUTTER_SHIFT);
        w_g1    = (w_gq == '0) ? DW'(1) : w_gq;
    end

    always_comb begin
        w_div    = DW'(w_frames);
        w_cand   = {r_rem, r_lo[DW-1]};
        w_take   = (w_cand >= {1'b0, w_div});
        w_rem_nx = w_take ? DW'(w_cand - {1'b0, w_div}) : w_cand[DW-1:0];
        w_lo_nx  = {r_lo[DW-2:0], w_take};
        w_q1     = (w_lo_nx == '0) ? DW'(1) : w_lo_nx;
        w_last   = (r_cnt == CNT_W'(DW - 1));
    end

    // next state
    always_comb begin
        case (r_state)
            fslm_pkg::DRV_LOAD:   n_state = fslm_pkg::DRV_CELL;
            fslm_pkg::DRV_CELL:   n_state = w_last ? fslm_pkg::DRV_GUTTER : fslm_pkg::DRV_CELL;
            fslm_pkg::DRV_GUTTER: n_state = fslm_pkg::DRV_DONE;
            fslm_pkg::DRV_DONE:   n_state = fslm_pkg::DRV_DONE;
            default:              n_state = fslm_pkg::DRV_LOAD;
        endcase
    end

    // outputs and divider datapath
    always_comb begin
        o_busy = (r_state != fslm_pkg::DRV_DONE);
        n_rem  = w_rem_nx;
        n_lo   = w_lo_nx;
        n_cnt  = CNT_W'(r_cnt + 1'b1);
        case (r_state)
            fslm_pkg::DRV_LOAD: begin
                n_rem = '0;
                n_lo  = w_w;
                n_cnt = '0;
            end
            fslm_pkg::DRV_GUTTER, fslm_pkg::DRV_DONE: begin
                n_rem = r_rem;
                n_lo  = r_lo;
                n_cnt = r_cnt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= fslm_pkg::DRV_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_lo  <= n_lo;
        if (r_state == fslm_pkg::DRV_LOAD) begin
            r_margin <= w_m1;
        end
        if (r_state == fslm_pkg::DRV_CELL && w_last) begin
            r_cell <= w_q1;
        end
        if (r_state == fslm_pkg::DRV_GUTTER) begin
            r_gutter <= w_g1;
        end
    end

    always_comb begin
        s_h    = $signed(GW'(w_h));
        s_m    = $signed(GW'(r_margin));
        s_cell = $signed(GW'(r_cell));
        s_g    = $signed(GW'(r_gutter));
        s_ch   = s_h - (s_m <<< 1);
        s_cw   = s_cell - (s_g <<< 1);
        w_half = (w_hs >> 1 == '0) ? fslm_pkg::CFG_HOLE_W'(1) : (w_hs >> 1);
        s_half = $signed(GW'(w_half));
        s_tcy  = s_m >>> 1;
        s_bcy  = s_h - (s_m >>> 1);

        o_geo.w           = GW'(w_w);
        o_geo.h           = GW'(w_h);
        o_geo.frames      = GW'(w_frames);
        o_geo.margin      = GW'(r_margin);
        o_geo.h_less_m    = GW'(w_h - r_margin);
        o_geo.ch          = (s_ch < 1) ? GW'(1) : GW'(s_ch);
        o_geo.cell_w      = GW'(r_cell);
        o_geo.gutter      = GW'(r_gutter);
        o_geo.cell_less_g = GW'(r_cell - r_gutter);
        o_geo.cw          = (s_cw < 1) ? GW'(1) : GW'(s_cw);
        o_geo.pitch       = {w_hs, 1'b0};
        o_geo.off         = 8'(w_hs >> 1);
        o_geo.off_end     = 8'(w_hs >> 1) + 8'(w_hs);
        o_geo.tlo         = s_tcy - s_half;
        o_geo.thi         = s_tcy + s_half;
        o_geo.blo         = s_bcy - s_half;
        o_geo.bhi         = s_bcy + s_half;
    end

endmodule

`default_nettype wire

// ----- rtl/fslm_checker.sv -----
// Port-level checks of the film-strip layout mapper, bound to the top level.
`default_nettype none

module fslm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic               o_strobe,
    input fslm_pkg::t_pix_out o_result
);

    a_class_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.pixel_class == fslm_pkg::CLASS_BLACK
                   || o_result.pixel_class == fslm_pkg::CLASS_HOLE
                   || o_result.pixel_class == fslm_pkg::CLASS_CONTENT))
        else $error("illegal pixel class");

    a_zero_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.pixel_class != fslm_pkg::CLASS_CONTENT)
        |-> (o_result.source_x == '0 && o_result.source_y == '0))
        else $error("source coordinate on a non-content pixel");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> busy)
        else $error("geometry not refreshed after a register write");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_strobe))
        else $error("block not quiet after reset");

endmodule

bind film_strip_layout_mapper fslm_checker u_fslm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
